/* rtl/ttc_pkg.sv */
// ttc_pkg: shared constants for the triangle triple counter
// no dependencies

package ttc_pkg;

    localparam int unsigned LEN_W         = 16;
    localparam int unsigned COUNT_W       = 16;
    localparam int unsigned MAX_ITEMS_DEF = 64;

endpackage

/* rtl/ttc_ram.sv */
// ttc_ram: generic one write port, one read port ram with registered read
// no dependencies

module ttc_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ttc_cell.sv */
// ttc_cell: one cell of the counting chain, holds one stored length
// depends on ttc_pkg

module ttc_cell
    import ttc_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int unsigned IDX       = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic [LEN_W-1:0]               load_len,
    input  logic [$clog2(MAX_ITEMS+1)-1:0] n_items,
    input  logic                           in_valid,
    input  logic [LEN_W-1:0]               in_x,
    input  logic [LEN_W-1:0]               in_y,
    input  logic [$clog2(MAX_ITEMS)-1:0]   in_j,
    input  logic [$clog2(MAX_ITEMS+1)-1:0] in_cnt,
    output logic                           out_valid,
    output logic [LEN_W-1:0]               out_x,
    output logic [LEN_W-1:0]               out_y,
    output logic [$clog2(MAX_ITEMS)-1:0]   out_j,
    output logic [$clog2(MAX_ITEMS+1)-1:0] out_cnt
);

    localparam int unsigned IW = $clog2(MAX_ITEMS);
    localparam int unsigned NW = $clog2(MAX_ITEMS + 1);
    localparam logic [NW-1:0] MY_IDX = NW'(IDX);

    logic [LEN_W-1:0] len_reg;
    logic             valid_reg;
    logic [LEN_W-1:0] x_reg;
    logic [LEN_W-1:0] y_reg;
    logic [IW-1:0]    j_reg;
    logic [NW-1:0]    cnt_reg;
    logic [LEN_W:0]   sum_xy;
    logic [LEN_W:0]   sum_xz;
    logic [LEN_W:0]   sum_yz;
    logic             in_range;
    logic             hit;

    // strict triangle test against the held length, zero never passes
    always_comb
    begin
        sum_xy   = {1'b0, in_x} + {1'b0, in_y};
        sum_xz   = {1'b0, in_x} + {1'b0, len_reg};
        sum_yz   = {1'b0, in_y} + {1'b0, len_reg};
        in_range = (MY_IDX > {1'b0, in_j}) && (MY_IDX < n_items);
        hit      = in_range && ({1'b0, len_reg} < sum_xy) &&
                   ({1'b0, in_y} < sum_xz) && ({1'b0, in_x} < sum_yz);
    end

    // held length
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            len_reg <= load_len;
        end
    end

    // pass the pair on to the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= in_x;
        y_reg   <= in_y;
        j_reg   <= in_j;
        cnt_reg <= in_cnt + NW'(hit);
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_j     = j_reg;
    assign out_cnt   = cnt_reg;

endmodule

/* rtl/triangle_triple_counter.sv */
// triangle_triple_counter: loads lengths, then counts valid triangle triples
// depends on ttc_pkg, ttc_ram, ttc_cell
// load: one length per cycle while busy is low.
// after the last length, busy stays high while each index pair walks the chain
// of cells and then while the chain drains.
// the result shows on done for one cycle; busy falls in that same cycle.
// reset clears the fill count, the overflow flag and the sequencer.

module triangle_triple_counter
    import ttc_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [LEN_W-1:0]   side_length,
    input  logic               last_item,
    output logic               done,
    output logic [COUNT_W-1:0] triangle_count,
    output logic               overflowed
);

    localparam int unsigned IW = $clog2(MAX_ITEMS);
    localparam int unsigned NW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned DW = $clog2(MAX_ITEMS + 4);
    localparam logic [DW-1:0] DRAIN_END = DW'(MAX_ITEMS + 3);
    localparam logic [NW-1:0] N_MAX     = NW'(MAX_ITEMS);
    localparam logic [NW-1:0] N_THREE   = NW'(3);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_PAIRS = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [NW-1:0]      n_reg, n_next;
    logic               ovf_reg, ovf_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [IW-1:0]      j_reg, j_next;
    logic [DW-1:0]      drain_reg, drain_next;
    logic [COUNT_W-1:0] acc_reg, acc_next;
    logic               done_reg, done_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               ovf_out_reg, ovf_out_next;
    logic               iss_valid_reg;
    logic [IW-1:0]      iss_j_reg;
    logic               accept;
    logic               we;
    logic [NW-1:0]      n_m2;
    logic [NW-1:0]      n_m3;
    logic [LEN_W-1:0]   rd_x;
    logic [LEN_W-1:0]   rd_y;

    logic               ch_valid [MAX_ITEMS+1];
    logic [LEN_W-1:0]   ch_x     [MAX_ITEMS+1];
    logic [LEN_W-1:0]   ch_y     [MAX_ITEMS+1];
    logic [IW-1:0]      ch_j     [MAX_ITEMS+1];
    logic [NW-1:0]      ch_cnt   [MAX_ITEMS+1];

    assign busy   = (state_reg != ST_LOAD);
    assign accept = start && !busy;
    assign we     = accept && (n_reg < N_MAX);
    assign n_m2   = n_reg - NW'(2);
    assign n_m3   = n_reg - NW'(3);

    // two copies of the store give both lengths of a pair in the same cycle
    ttc_ram #(.WIDTH(LEN_W), .DEPTH(MAX_ITEMS)) u_ram_x (
        .clk   (clk),
        .we    (we),
        .waddr (n_reg[IW-1:0]),
        .wdata (side_length),
        .raddr (i_reg),
        .rdata (rd_x)
    );

    ttc_ram #(.WIDTH(LEN_W), .DEPTH(MAX_ITEMS)) u_ram_y (
        .clk   (clk),
        .we    (we),
        .waddr (n_reg[IW-1:0]),
        .wdata (side_length),
        .raddr (j_reg),
        .rdata (rd_y)
    );

    // chain head takes the pair read out of the store
    assign ch_valid[0] = iss_valid_reg;
    assign ch_x[0]     = rd_x;
    assign ch_y[0]     = rd_y;
    assign ch_j[0]     = iss_j_reg;
    assign ch_cnt[0]   = '0;

    // row of cells, cell k holds length k
    for (genvar k = 0; k < MAX_ITEMS; k++)
    begin : g_cell
        ttc_cell #(.MAX_ITEMS(MAX_ITEMS), .IDX(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (we && (n_reg == NW'(k))),
            .load_len  (side_length),
            .n_items   (n_reg),
            .in_valid  (ch_valid[k]),
            .in_x      (ch_x[k]),
            .in_y      (ch_y[k]),
            .in_j      (ch_j[k]),
            .in_cnt    (ch_cnt[k]),
            .out_valid (ch_valid[k+1]),
            .out_x     (ch_x[k+1]),
            .out_y     (ch_y[k+1]),
            .out_j     (ch_j[k+1]),
            .out_cnt   (ch_cnt[k+1])
        );
    end

    // sequencer: load, walk index pairs, drain the chain
    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        ovf_next     = ovf_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        drain_next   = drain_reg;
        acc_next     = acc_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        ovf_out_next = ovf_out_reg;
        if (ch_valid[MAX_ITEMS])
        begin
            acc_next = acc_reg + COUNT_W'(ch_cnt[MAX_ITEMS]);
        end
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (we)
                    begin
                        n_next = n_reg + NW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_item)
                    begin
                        i_next     = '0;
                        j_next     = IW'(1);
                        drain_next = '0;
                        acc_next   = '0;
                        state_next = (n_next < N_THREE) ? ST_DRAIN : ST_PAIRS;
                    end
                end
            end
            ST_PAIRS:
            begin
                if ({1'b0, j_reg} == n_m2)
                begin
                    if ({1'b0, i_reg} == n_m3)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + IW'(1);
                        j_next = i_reg + IW'(2);
                    end
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + DW'(1);
                if (drain_reg == DRAIN_END)
                begin
                    done_next    = 1'b1;
                    count_next   = acc_reg;
                    ovf_out_next = ovf_reg;
                    n_next       = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            n_reg         <= '0;
            ovf_reg       <= 1'b0;
            done_reg      <= 1'b0;
            iss_valid_reg <= 1'b0;
            drain_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            ovf_reg       <= ovf_next;
            done_reg      <= done_next;
            iss_valid_reg <= (state_reg == ST_PAIRS);
            drain_reg     <= drain_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        acc_reg     <= acc_next;
        count_reg   <= count_next;
        ovf_out_reg <= ovf_out_next;
        iss_j_reg   <= j_reg;
    end

    assign done           = done_reg;
    assign triangle_count = count_reg;
    assign overflowed     = ovf_out_reg;

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_MAX)
        else $error("fill count beyond store depth");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_item |=> busy)
        else $error("closing transaction did not start counting");

    a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (n_reg == '0) && !ovf_reg && !busy)
        else $error("store not emptied with result");

    a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        iss_valid_reg |-> busy)
        else $error("pair issued while idle");

endmodule
